// ===== rtl/cupf_pkg.sv =====
package cupf_pkg;

    localparam int MAX_POINTS = 256;
    localparam int PT_AW      = $clog2(MAX_POINTS);
    localparam int CNT_W      = PT_AW + 1;
    localparam int MAX_ORDER  = 15;
    localparam int ORD_AW     = $clog2(MAX_ORDER + 1);
    localparam int MAX_OUT    = 64;
    localparam int OUT_W      = $clog2(MAX_OUT);

    localparam int DIV_STEPS  = 80;
    localparam int DIV_CNT_W  = $clog2(DIV_STEPS);

    localparam int STEP_W     = 18;
    localparam int CFG_W      = 18;

    // register indexes
    localparam logic REG_POLY_DEGREE = 1'b0;
    localparam logic REG_SAMPLE_STEP = 1'b1;

    // result status codes
    localparam logic [1:0] FIT_OK        = 2'd0;
    localparam logic [1:0] FIT_ZERO_SPAN = 2'd1;
    localparam logic [1:0] FIT_OVERFLOW  = 2'd2;

    localparam logic signed [31:0] ONE_Q16 = 32'sh0001_0000;
    localparam logic signed [31:0] ONE_Q30 = 32'sh4000_0000;

    typedef enum logic [4:0] {
        S_IDLE,
        S_CLOSE,
        S_LOW,
        S_HIGH,
        S_SPAN,
        S_CLR,
        S_PRD,
        S_PDAT,
        S_PDIV,
        S_ACC_RD,
        S_ACC_WR,
        S_COEF,
        S_CDAT,
        S_CDIV,
        S_ORUN,
        S_XMUL,
        S_EV_RD,
        S_EV_MUL,
        S_EV_ACC,
        S_EMIT
    } t_state;

    typedef struct packed {
        logic        go;
        logic        frac30;
        logic        neg;
        logic [63:0] un;
        logic [63:0] ud;
    } t_div_req;

    typedef struct packed {
        logic               done;
        logic signed [31:0] q;
    } t_div_rsp;

    function automatic logic signed [31:0] sat32(input logic signed [65:0] v);
        if (v > 66'sd2147483647) begin
            return 32'sh7fff_ffff;
        end else if (v < -66'sd2147483648) begin
            return 32'sh8000_0000;
        end else begin
            return v[31:0];
        end
    endfunction

endpackage

// ===== rtl/cupf_ram.sv =====
module cupf_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end

endmodule

// ===== rtl/cupf_div.sv =====
module cupf_div (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  cupf_pkg::t_div_req i_req,
    output cupf_pkg::t_div_rsp o_rsp
);
    import cupf_pkg::*;

    logic                 r_act;
    logic [DIV_CNT_W-1:0] r_cnt;
    logic [79:0]          r_dvd;
    logic [63:0]          r_rem;
    logic [63:0]          r_ud;
    logic [31:0]          r_q;
    logic                 r_sat;
    logic                 r_neg;
    logic                 r_done;
    logic signed [31:0]   r_res;

    logic [64:0] rem_sh;
    logic        ge;
    logic [63:0] rem_nx;
    logic [31:0] q_nx;
    logic        sat_nx;
    logic [31:0] lim;
    logic [31:0] q_fin;

    always_comb begin
        rem_sh = {r_rem, r_dvd[79]};
        ge     = rem_sh >= {1'b0, r_ud};
        rem_nx = ge ? 64'(rem_sh - {1'b0, r_ud}) : rem_sh[63:0];
        q_nx   = {r_q[30:0], ge};
        // any quotient bit above 32 bits forces saturation
        sat_nx = r_sat | r_q[31];
        lim    = r_neg ? 32'h8000_0000 : 32'h7fff_ffff;
        q_fin  = (sat_nx || (q_nx > lim)) ? lim : q_nx;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_act  <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_done <= 1'b0;
            if (i_req.go) begin
                if (i_req.ud == 64'd0) begin
                    r_done <= 1'b1;
                    r_res  <= 32'sd0;
                end else begin
                    r_act <= 1'b1;
                    r_cnt <= '0;
                    r_dvd <= i_req.frac30 ? {i_req.un[49:0], 30'b0} : {i_req.un, 16'b0};
                    r_rem <= '0;
                    r_ud  <= i_req.ud;
                    r_q   <= '0;
                    r_sat <= 1'b0;
                    r_neg <= i_req.neg;
                end
            end else if (r_act) begin
                r_dvd <= {r_dvd[78:0], 1'b0};
                r_rem <= rem_nx;
                r_q   <= q_nx;
                r_sat <= sat_nx;
                if (r_cnt == DIV_CNT_W'(DIV_STEPS - 1)) begin
                    r_act  <= 1'b0;
                    r_done <= 1'b1;
                    r_res  <= r_neg ? $signed(32'(-q_fin)) : $signed(q_fin);
                end else begin
                    r_cnt <= r_cnt + 1'b1;
                end
            end
        end
    end

    assign o_rsp.done = r_done;
    assign o_rsp.q    = r_res;

endmodule

// ===== rtl/chebyshev_u_projection_fit.sv =====
// Loading item: one point store write unless the store is full, taken only while idle; busy stays low.
// Closing item: the fit finds the span, clears the sums, then uses an 80 step shared divider per
// point and per coefficient, then evaluates the results one at a time. Results come as
// one-cycle strobes; the receiver cannot stall.
// Reset (synchronous, active low) clears the point count, overflow flag, state and strobe;
// stores hold no reset value; degree and sample step reset to 3 and 6554.
module chebyshev_u_projection_fit (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      start,
    output logic                      busy,
    input  logic signed [31:0]        i_point_x,
    input  logic signed [31:0]        i_point_y,
    input  logic                      i_last_point,
    input  logic                      i_cfg_we,
    input  logic                      i_cfg_idx,
    input  logic [cupf_pkg::CFG_W-1:0] i_cfg_data,
    output logic                      o_strobe,
    output logic signed [31:0]        o_curve_x,
    output logic signed [31:0]        o_curve_y,
    output logic                      o_last_result,
    output logic [1:0]                o_fit_status
);
    import cupf_pkg::*;

    t_state r_state, n_state;

    logic [CNT_W-1:0]  r_cnt, r_n;
    logic              r_ovf, r_ovf_run;
    logic [ORD_AW-1:0] r_deg, r_i;
    logic [STEP_W-1:0] r_step;
    logic [PT_AW-1:0]  r_j;
    logic [OUT_W-1:0]  r_k;
    logic              r_final;
    logic signed [31:0] r_low, r_high, r_mid, r_y, r_t, r_u0, r_u1;
    logic signed [32:0] r_span;
    logic signed [63:0] r_py, r_pu, r_pt, r_acc;
    logic signed [64:0] r_px;
    logic signed [33:0] r_tq;

    // store ports
    logic              p_we;
    logic [PT_AW-1:0]  p_waddr, p_raddr;
    logic [63:0]       p_rdata;
    logic              a_we;
    logic [127:0]      a_wdata, a_rdata;
    logic              c_we;
    logic [31:0]       c_rdata;

    t_div_req div_req;
    t_div_rsp div_rsp;

    logic               accept;
    logic [CNT_W-1:0]   cnt_after;
    logic signed [31:0] x_rd, u1_nx, t_fit;
    logic signed [32:0] x_diff;
    logic signed [63:0] d64, s64, num64, den64;
    logic signed [33:0] t2;
    logic               last_order, last_point;

    assign busy   = (r_state != S_IDLE);
    assign accept = start && !busy;

    assign cnt_after  = r_cnt[PT_AW] ? r_cnt : r_cnt + 1'b1;
    assign last_order = (r_i == r_deg);
    assign last_point = ({1'b0, r_j} == CNT_W'(r_n - 1'b1));

    always_comb begin
        x_rd   = $signed(p_rdata[63:32]);
        x_diff = {x_rd[31], x_rd} - {r_low[31], r_low};
        d64    = 64'(x_diff);
        s64    = 64'(r_span);
        num64  = $signed(a_rdata[127:64]);
        den64  = $signed(a_rdata[63:0]);
        u1_nx  = sat32(66'(r_pt >>> 29) - 66'(r_u0));
        t2     = {div_rsp.q[31], div_rsp.q, 1'b0} - 34'sd1073741824;
        t_fit  = sat32(66'(t2));
        a_wdata = {64'(num64 + (r_py >>> 16)), 64'(den64 + (r_pu >>> 16))};
    end

    cupf_ram #(.WIDTH(64), .DEPTH(MAX_POINTS)) u_pts (
        .i_clk   (i_clk),
        .i_we    (p_we),
        .i_waddr (p_waddr),
        .i_wdata ({i_point_x, i_point_y}),
        .i_raddr (p_raddr),
        .o_rdata (p_rdata)
    );

    cupf_ram #(.WIDTH(128), .DEPTH(MAX_ORDER + 1)) u_acc (
        .i_clk   (i_clk),
        .i_we    (a_we),
        .i_waddr (r_i),
        .i_wdata ((r_state == S_CLR) ? 128'd0 : a_wdata),
        .i_raddr (r_i),
        .o_rdata (a_rdata)
    );

    cupf_ram #(.WIDTH(32), .DEPTH(MAX_ORDER + 1)) u_coef (
        .i_clk   (i_clk),
        .i_we    (c_we),
        .i_waddr (r_i),
        .i_wdata (div_rsp.q),
        .i_raddr (r_i),
        .o_rdata (c_rdata)
    );

    cupf_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (div_req),
        .o_rsp   (div_rsp)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        p_we    = 1'b0;
        p_waddr = r_cnt[PT_AW-1:0];
        p_raddr = r_j;
        a_we    = 1'b0;
        c_we    = 1'b0;
        div_req = '0;
        case (r_state)
            S_IDLE: begin
                p_we = accept && !r_cnt[PT_AW];
                if (accept && i_last_point) begin
                    n_state = S_CLOSE;
                end
            end
            S_CLOSE: begin
                p_raddr = '0;
                n_state = r_ovf_run ? S_IDLE : S_LOW;
            end
            S_LOW: begin
                p_raddr = PT_AW'(r_n - 1'b1);
                n_state = S_HIGH;
            end
            S_HIGH: n_state = S_SPAN;
            S_SPAN: n_state = (r_span == 33'sd0) ? S_IDLE : S_CLR;
            S_CLR: begin
                a_we    = 1'b1;
                n_state = last_order ? S_PRD : S_CLR;
            end
            S_PRD: n_state = S_PDAT;
            S_PDAT: begin
                div_req.go     = 1'b1;
                div_req.frac30 = 1'b1;
                div_req.neg    = x_diff[32] ^ r_span[32];
                div_req.un     = d64[63] ? 64'(-d64) : d64;
                div_req.ud     = s64[63] ? 64'(-s64) : s64;
                n_state        = S_PDIV;
            end
            S_PDIV: n_state = div_rsp.done ? S_ACC_RD : S_PDIV;
            S_ACC_RD: n_state = S_ACC_WR;
            S_ACC_WR: begin
                a_we = 1'b1;
                if (!last_order) begin
                    n_state = S_ACC_RD;
                end else begin
                    n_state = last_point ? S_COEF : S_PRD;
                end
            end
            S_COEF: n_state = S_CDAT;
            S_CDAT: begin
                div_req.go     = 1'b1;
                div_req.frac30 = 1'b0;
                div_req.neg    = num64[63] ^ den64[63];
                div_req.un     = num64[63] ? 64'(-num64) : num64;
                div_req.ud     = den64[63] ? 64'(-den64) : den64;
                n_state        = S_CDIV;
            end
            S_CDIV: begin
                if (div_rsp.done) begin
                    c_we    = 1'b1;
                    n_state = last_order ? S_ORUN : S_COEF;
                end
            end
            S_ORUN:   n_state = S_XMUL;
            S_XMUL:   n_state = S_EV_RD;
            S_EV_RD:  n_state = S_EV_MUL;
            S_EV_MUL: n_state = S_EV_ACC;
            S_EV_ACC: n_state = last_order ? S_EMIT : S_EV_RD;
            S_EMIT:   n_state = r_final ? S_IDLE : S_ORUN;
            default:  n_state = S_IDLE;
        endcase
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt     <= '0;
            r_ovf     <= 1'b0;
            r_deg     <= ORD_AW'(3);
            r_step    <= STEP_W'(6554);
            o_strobe  <= 1'b0;
        end else begin
            o_strobe <= 1'b0;
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    REG_POLY_DEGREE: r_deg  <= i_cfg_data[ORD_AW-1:0];
                    REG_SAMPLE_STEP: r_step <= i_cfg_data[STEP_W-1:0];
                    default: ;
                endcase
            end
            if (accept) begin
                if (i_last_point) begin
                    // close the run: hand count and overflow to the fit
                    r_n       <= cnt_after;
                    r_ovf_run <= r_ovf | r_cnt[PT_AW];
                    r_cnt     <= '0;
                    r_ovf     <= 1'b0;
                end else begin
                    r_cnt <= cnt_after;
                    r_ovf <= r_ovf | r_cnt[PT_AW];
                end
            end
            case (r_state)
                S_CLOSE: begin
                    if (r_ovf_run) begin
                        o_strobe      <= 1'b1;
                        o_curve_x     <= '0;
                        o_curve_y     <= '0;
                        o_last_result <= 1'b1;
                        o_fit_status  <= FIT_OVERFLOW;
                    end
                end
                S_SPAN: begin
                    if (r_span == 33'sd0) begin
                        o_strobe      <= 1'b1;
                        o_curve_x     <= '0;
                        o_curve_y     <= '0;
                        o_last_result <= 1'b1;
                        o_fit_status  <= FIT_ZERO_SPAN;
                    end
                end
                S_EMIT: begin
                    o_strobe      <= 1'b1;
                    o_curve_x     <= sat32(66'(r_mid) + 66'(r_px >>> 31));
                    o_curve_y     <= sat32(66'(r_acc));
                    o_last_result <= r_final;
                    o_fit_status  <= FIT_OK;
                end
                default: ;
            endcase
        end
    end

    // datapath registers
    always_ff @(posedge i_clk) begin
        case (r_state)
            S_LOW: r_low <= x_rd;
            S_HIGH: begin
                r_high <= x_rd;
                r_span <= {x_rd[31], x_rd} - {r_low[31], r_low};
            end
            S_SPAN: begin
                r_mid <= 32'(({r_low[31], r_low} + {r_high[31], r_high}) >>> 1);
                r_i   <= '0;
            end
            S_CLR: begin
                r_i <= last_order ? '0 : r_i + 1'b1;
                r_j <= '0;
            end
            S_PDAT: r_y <= $signed(p_rdata[31:0]);
            S_PDIV: begin
                r_t  <= t_fit;
                r_u0 <= '0;
                r_u1 <= ONE_Q16;
                r_i  <= '0;
            end
            S_ACC_RD: begin
                r_py <= r_y * r_u1;
                r_pu <= r_u1 * r_u1;
                r_pt <= r_t * r_u1;
            end
            S_ACC_WR: begin
                r_u0 <= r_u1;
                r_u1 <= u1_nx;
                if (last_order) begin
                    r_i <= '0;
                    r_j <= r_j + 1'b1;
                end else begin
                    r_i <= r_i + 1'b1;
                end
            end
            S_CDIV: begin
                if (div_rsp.done) begin
                    r_i  <= last_order ? '0 : r_i + 1'b1;
                    r_tq <= -34'sd1073741824;
                    r_k  <= '0;
                end
            end
            S_ORUN: begin
                // stepped point while inside the range and under the result limit, else the closing point
                if ((r_tq <= 34'sd1073741824) && (r_k != OUT_W'(MAX_OUT - 1))) begin
                    r_t     <= r_tq[31:0];
                    r_final <= 1'b0;
                end else begin
                    r_t     <= ONE_Q30;
                    r_final <= 1'b1;
                end
            end
            S_XMUL: begin
                r_px  <= r_span * r_t;
                r_acc <= '0;
                r_u0  <= '0;
                r_u1  <= ONE_Q16;
                r_i   <= '0;
            end
            S_EV_MUL: begin
                r_py <= $signed(c_rdata) * r_u1;
                r_pt <= r_t * r_u1;
            end
            S_EV_ACC: begin
                r_acc <= r_acc + (r_py >>> 16);
                r_u0  <= r_u1;
                r_u1  <= u1_nx;
                r_i   <= last_order ? r_i : r_i + 1'b1;
            end
            S_EMIT: begin
                r_k  <= r_k + 1'b1;
                r_tq <= r_tq + $signed({2'b00, r_step, 14'b0});
            end
            default: ;
        endcase
    end

    a_last_frees: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_strobe && o_last_result |-> !busy)
        else $error("final result while still busy");

    a_error_is_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_strobe && (o_fit_status != FIT_OK) |-> o_last_result)
        else $error("error status on a non-final result");

    a_close_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        start && !busy && i_last_point |=> busy)
        else $error("closing item did not start the fit");

    a_strobe_gap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_strobe && !o_last_result |=> !o_strobe)
        else $error("stepped results not separated by evaluation");

endmodule
